// File: rtl/core/tbrs_pkg.sv
// ----------------------------------------------------------------------------
// tbrs_pkg
// types and constants shared by the tape block request sequencer modules
// ----------------------------------------------------------------------------
package tbrs_pkg;

    localparam logic [2:0] CMD_OPEN   = 3'd0;
    localparam logic [2:0] CMD_CLOSE  = 3'd1;
    localparam logic [2:0] CMD_REQ    = 3'd2;
    localparam logic [2:0] CMD_INTR   = 3'd3;
    localparam logic [2:0] CMD_SETPOS = 3'd4;

    localparam logic [1:0] RK_REG    = 2'd0;
    localparam logic [1:0] RK_DONE   = 2'd1;
    localparam logic [1:0] RK_REFUSE = 2'd2;

    localparam logic [1:0] ST_CLOSED = 2'd0;
    localparam logic [1:0] ST_OPEN   = 2'd1;
    localparam logic [1:0] ST_FAILED = 2'd2;

    localparam logic [15:0] C_GO   = 16'o1;
    localparam logic [15:0] C_READ = 16'o2;
    localparam logic [15:0] C_WRITE = 16'o4;
    localparam logic [15:0] C_WEOF = 16'o6;
    localparam logic [15:0] C_SFWD = 16'o10;
    localparam logic [15:0] C_SREV = 16'o12;
    localparam logic [15:0] C_WGAP = 16'o14;
    localparam logic [15:0] C_REW  = 16'o16;
    localparam logic [15:0] C_DENS = 16'o60000;
    localparam logic [15:0] C_IENA = 16'o100;
    localparam logic [15:0] E_HARD = 16'o102200;
    localparam logic [15:0] E_EOF  = 16'o40000;
    localparam logic [15:0] LIMIT_OPEN = 16'hFFFF;

    localparam logic [3:0] RETRY_RESET = 4'd10;
    localparam logic [2:0] ADDR_RETRY  = 3'd0;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_SEEK = 2'd1,
        PH_IO   = 2'd2
    } t_phase;

    typedef enum logic [3:0] {
        J_NOP      = 4'd0,
        J_OPEN     = 4'd1,
        J_OPEN_REF = 4'd2,
        J_CLOSE    = 4'd3,
        J_REQ_FAIL = 4'd4,
        J_REQ_ZERO = 4'd5,
        J_REQ_PUSH = 4'd6,
        J_INTR     = 4'd7,
        J_SETPOS   = 4'd8
    } t_jkind;

    typedef struct packed {
        logic [2:0]  unit;
        logic [15:0] block;
        logic        wr;
        logic [1:0]  ext;
        logic [15:0] wc;
        logic [15:0] addr;
        logic        raw;
    } t_req;

    typedef struct packed {
        t_jkind      kind;
        t_req        req;
        logic        ready;
        logic        cerr;
        logic [15:0] err;
        logic [15:0] bc;
    } t_job;

    typedef struct packed {
        logic [1:0]  kind;
        logic [2:0]  unit;
        logic [15:0] status;
        logic [15:0] count;
        logic        cv;
        logic [15:0] addr;
        logic        av;
        logic        failed;
        logic        zf;
        logic [15:0] resid;
        logic        last;
    } t_res;

    typedef struct packed {
        logic idle;
        logic full;
    } t_bstat;

endpackage

// File: rtl/core/tape_block_request_sequencer.sv
// ----------------------------------------------------------------------------
// tape_block_request_sequencer
// block request sequencer for up to eight tape units
//
//  channel  handshake          payload
//  in       i_valid/o_stall    i_command .. i_byte_residual
//  out      o_valid/i_stall    o_result_kind .. o_last
//  cfg      psel/penable/..    paddr, pwdata, prdata (retry limit)
//
// the back-end sequencer handles one event at a time
// a new event is taken once the job queue is empty and the back end is idle
// a pending result in the output register does not block the front end
// reset is synchronous; no clearing pass
// ----------------------------------------------------------------------------
module tape_block_request_sequencer #(
    parameter int UNIT_COUNT  = 8,
    parameter int QUEUE_DEPTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [2:0]  i_command,
    input  logic [2:0]  i_unit,
    input  logic [15:0] i_block,
    input  logic        i_access_write,
    input  logic [1:0]  i_addr_ext,
    input  logic [15:0] i_word_count,
    input  logic [15:0] i_core_addr,
    input  logic        i_is_raw,
    input  logic        i_ctrl_ready,
    input  logic        i_ctrl_error,
    input  logic [15:0] i_error_reg,
    input  logic [15:0] i_byte_residual,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_result_kind,
    output logic [2:0]  o_unit_res,
    output logic [15:0] o_status_word,
    output logic [15:0] o_count_word,
    output logic        o_count_valid,
    output logic [15:0] o_address_word,
    output logic        o_address_valid,
    output logic        o_failed,
    output logic        o_zero_fill,
    output logic [15:0] o_residual,
    output logic        o_last,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [3:0]             r_retry_limit;
    tbrs_pkg::t_bstat       bstat;
    logic [UNIT_COUNT-1:0]  closed;
    logic                   jq_empty;
    logic                   jq_push;
    logic                   jq_pop;
    tbrs_pkg::t_job         f_job;
    tbrs_pkg::t_job         q_job;
    tbrs_pkg::t_res         res;

    assign pready = 1'b1;
    assign prdata = (paddr == tbrs_pkg::ADDR_RETRY) ? {28'd0, r_retry_limit} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_retry_limit <= tbrs_pkg::RETRY_RESET;
        end else if (psel && penable && pwrite && pready &&
                     paddr == tbrs_pkg::ADDR_RETRY) begin
            r_retry_limit <= pwdata[3:0];
        end
    end

    tbrs_front #(
        .UNIT_COUNT (UNIT_COUNT)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_command       (i_command),
        .i_unit          (i_unit),
        .i_block         (i_block),
        .i_access_write  (i_access_write),
        .i_addr_ext      (i_addr_ext),
        .i_word_count    (i_word_count),
        .i_core_addr     (i_core_addr),
        .i_is_raw        (i_is_raw),
        .i_ctrl_ready    (i_ctrl_ready),
        .i_ctrl_error    (i_ctrl_error),
        .i_error_reg     (i_error_reg),
        .i_byte_residual (i_byte_residual),
        .i_bstat         (bstat),
        .i_closed        (closed),
        .i_jq_empty      (jq_empty),
        .o_push          (jq_push),
        .o_job           (f_job)
    );

    tbrs_jobq u_jobq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (jq_push),
        .i_job   (f_job),
        .i_pop   (jq_pop),
        .o_empty (jq_empty),
        .o_job   (q_job)
    );

    tbrs_back #(
        .UNIT_COUNT  (UNIT_COUNT),
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_retry_limit (r_retry_limit),
        .i_jq_empty    (jq_empty),
        .i_job         (q_job),
        .o_jq_pop      (jq_pop),
        .o_bstat       (bstat),
        .o_closed      (closed),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_res         (res)
    );

    assign o_result_kind   = res.kind;
    assign o_unit_res      = res.unit;
    assign o_status_word   = res.status;
    assign o_count_word    = res.count;
    assign o_count_valid   = res.cv;
    assign o_address_word  = res.addr;
    assign o_address_valid = res.av;
    assign o_failed        = res.failed;
    assign o_zero_fill     = res.zf;
    assign o_residual      = res.resid;
    assign o_last          = res.last;

endmodule

// File: rtl/core/tbrs_jobq.sv
// ----------------------------------------------------------------------------
// tbrs_jobq
// two-entry queue of classified jobs between front and back
// ----------------------------------------------------------------------------
module tbrs_jobq (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  tbrs_pkg::t_job  i_job,
    input  logic            i_pop,
    output logic            o_empty,
    output tbrs_pkg::t_job  o_job
);

    tbrs_pkg::t_job r_data [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;

    assign o_empty = (r_cnt == 2'd0);
    assign o_job   = r_data[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_data[r_wp] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, i_pop};
        end
    end

endmodule

// File: rtl/core/tbrs_front.sv
// ----------------------------------------------------------------------------
// tbrs_front
// accepts events, keeps record limits and classifies each event into a job
// ----------------------------------------------------------------------------
module tbrs_front #(
    parameter int UNIT_COUNT = 8
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_stall,
    input  logic [2:0]             i_command,
    input  logic [2:0]             i_unit,
    input  logic [15:0]            i_block,
    input  logic                   i_access_write,
    input  logic [1:0]             i_addr_ext,
    input  logic [15:0]            i_word_count,
    input  logic [15:0]            i_core_addr,
    input  logic                   i_is_raw,
    input  logic                   i_ctrl_ready,
    input  logic                   i_ctrl_error,
    input  logic [15:0]            i_error_reg,
    input  logic [15:0]            i_byte_residual,
    input  tbrs_pkg::t_bstat       i_bstat,
    input  logic [UNIT_COUNT-1:0]  i_closed,
    input  logic                   i_jq_empty,
    output logic                   o_push,
    output tbrs_pkg::t_job         o_job
);

    localparam int UIW = (UNIT_COUNT > 1) ? $clog2(UNIT_COUNT) : 1;

    logic [15:0] r_limit [UNIT_COUNT];

    logic            accept;
    logic            valid_u;
    logic [UIW-1:0]  ui;
    logic [15:0]     lim;
    logic            u_closed;
    tbrs_pkg::t_jkind kind;

    assign o_stall  = !(i_bstat.idle && i_jq_empty);
    assign accept   = i_valid && !o_stall;
    assign valid_u  = ({1'b0, i_unit} < 4'(UNIT_COUNT));
    assign ui       = i_unit[UIW-1:0];
    assign lim      = valid_u ? r_limit[ui] : 16'd0;
    assign u_closed = valid_u ? i_closed[ui] : 1'b0;

    always_comb begin
        kind = tbrs_pkg::J_NOP;
        unique case (i_command)
            tbrs_pkg::CMD_OPEN: begin
                kind = u_closed ? tbrs_pkg::J_OPEN : tbrs_pkg::J_OPEN_REF;
            end
            tbrs_pkg::CMD_CLOSE: begin
                kind = valid_u ? tbrs_pkg::J_CLOSE : tbrs_pkg::J_NOP;
            end
            tbrs_pkg::CMD_REQ: begin
                if (!valid_u || i_bstat.full || lim < i_block) begin
                    kind = tbrs_pkg::J_REQ_FAIL;
                end else if (lim == i_block && !i_access_write) begin
                    kind = tbrs_pkg::J_REQ_ZERO;
                end else begin
                    kind = tbrs_pkg::J_REQ_PUSH;
                end
            end
            tbrs_pkg::CMD_INTR: begin
                kind = tbrs_pkg::J_INTR;
            end
            tbrs_pkg::CMD_SETPOS: begin
                kind = valid_u ? tbrs_pkg::J_SETPOS : tbrs_pkg::J_NOP;
            end
            default: begin
                kind = tbrs_pkg::J_NOP;
            end
        endcase
    end

    always_comb begin
        o_job.kind       = kind;
        o_job.req.unit   = i_unit;
        o_job.req.block  = i_block;
        o_job.req.wr     = i_access_write;
        o_job.req.ext    = i_addr_ext;
        o_job.req.wc     = i_word_count;
        o_job.req.addr   = i_core_addr;
        o_job.req.raw    = i_is_raw;
        o_job.ready      = i_ctrl_ready;
        o_job.cerr       = i_ctrl_error;
        o_job.err        = i_error_reg;
        o_job.bc         = i_byte_residual;
    end

    assign o_push = accept && (kind != tbrs_pkg::J_NOP);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < UNIT_COUNT; k++) begin
                r_limit[k] <= 16'd0;
            end
        end else if (accept) begin
            if (kind == tbrs_pkg::J_OPEN) begin
                r_limit[ui] <= tbrs_pkg::LIMIT_OPEN;
            end else if ((kind == tbrs_pkg::J_REQ_PUSH && i_access_write) ||
                         kind == tbrs_pkg::J_SETPOS) begin
                r_limit[ui] <= i_block + 16'd1;
            end
        end
    end

endmodule

// File: rtl/core/tbrs_back.sv
// ----------------------------------------------------------------------------
// tbrs_back
// carries out jobs: unit state, request fifo, seek and transfer sequencing
// ----------------------------------------------------------------------------
module tbrs_back #(
    parameter int UNIT_COUNT  = 8,
    parameter int QUEUE_DEPTH = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic [3:0]             i_retry_limit,
    input  logic                   i_jq_empty,
    input  tbrs_pkg::t_job         i_job,
    output logic                   o_jq_pop,
    output tbrs_pkg::t_bstat       o_bstat,
    output logic [UNIT_COUNT-1:0]  o_closed,
    output logic                   o_valid,
    input  logic                   i_stall,
    output tbrs_pkg::t_res         o_res
);

    localparam int UIW = (UNIT_COUNT > 1) ? $clog2(UNIT_COUNT) : 1;
    localparam int QIW = $clog2(QUEUE_DEPTH);
    localparam int CW  = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_EMIT1 = 6'b000010,
        S_REW   = 6'b000100,
        S_LOAD  = 6'b001000,
        S_START = 6'b010000,
        S_INTR  = 6'b100000
    } t_state;

    t_state           r_state, n_state;
    tbrs_pkg::t_job   r_job;
    logic             r_after_intr, n_after_intr;
    tbrs_pkg::t_phase r_phase, n_phase;
    logic [3:0]       r_ec, n_ec;
    logic [1:0]       r_ustate [UNIT_COUNT];
    logic [15:0]      r_pos [UNIT_COUNT];
    tbrs_pkg::t_req   r_mem [QUEUE_DEPTH];
    tbrs_pkg::t_req   r_hdata;
    logic [QIW-1:0]   r_hptr, r_tptr;
    logic [CW-1:0]    r_count;
    logic             r_ovalid;
    tbrs_pkg::t_res   r_res;

    logic             out_free;
    logic             emit;
    tbrs_pkg::t_res   res;
    logic             do_push, do_pop;
    logic             pos_we, us_we;
    logic [UIW-1:0]   pos_wa, us_wa;
    logic [15:0]      pos_wd;
    logic [1:0]       us_wd;
    logic [UIW-1:0]   hu, ju;
    logic [15:0]      hpos, com;
    logic [3:0]       ec1;
    logic             soft_err, fail;

    assign out_free = !r_ovalid || !i_stall;
    assign hu       = r_hdata.unit[UIW-1:0];
    assign ju       = i_job.req.unit[UIW-1:0];
    assign hpos     = r_pos[hu];
    assign com      = {5'd0, r_hdata.unit, 2'd0, r_hdata.ext, 4'd0}
                      | tbrs_pkg::C_IENA | tbrs_pkg::C_DENS;
    assign ec1      = r_ec + 4'd1;
    assign soft_err = r_job.cerr && r_phase == tbrs_pkg::PH_IO &&
                      (r_job.err & (tbrs_pkg::E_HARD | tbrs_pkg::E_EOF)) == 16'd0;

    always_comb begin
        n_state      = r_state;
        n_after_intr = r_after_intr;
        n_phase      = r_phase;
        n_ec         = r_ec;
        o_jq_pop     = 1'b0;
        emit         = 1'b0;
        res          = '0;
        do_push      = 1'b0;
        do_pop       = 1'b0;
        pos_we       = 1'b0;
        pos_wa       = hu;
        pos_wd       = 16'd0;
        us_we        = 1'b0;
        us_wa        = hu;
        us_wd        = tbrs_pkg::ST_CLOSED;
        fail         = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (!i_jq_empty) begin
                    o_jq_pop = 1'b1;
                    case (i_job.kind)
                        tbrs_pkg::J_OPEN: begin
                            us_we  = 1'b1;
                            us_wa  = ju;
                            us_wd  = tbrs_pkg::ST_OPEN;
                            pos_we = 1'b1;
                            pos_wa = ju;
                        end
                        tbrs_pkg::J_SETPOS: begin
                            pos_we = 1'b1;
                            pos_wa = ju;
                            pos_wd = i_job.req.block;
                        end
                        tbrs_pkg::J_CLOSE: begin
                            us_we   = 1'b1;
                            us_wa   = ju;
                            n_state = i_job.req.wr ? S_EMIT1 : S_REW;
                        end
                        tbrs_pkg::J_OPEN_REF, tbrs_pkg::J_REQ_FAIL,
                        tbrs_pkg::J_REQ_ZERO: begin
                            n_state = S_EMIT1;
                        end
                        tbrs_pkg::J_REQ_PUSH: begin
                            do_push = 1'b1;
                            if (r_phase == tbrs_pkg::PH_IDLE) begin
                                n_after_intr = 1'b0;
                                n_state      = S_LOAD;
                            end
                        end
                        tbrs_pkg::J_INTR: begin
                            if (r_count != '0) begin
                                n_after_intr = 1'b1;
                                n_state      = S_LOAD;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_EMIT1: begin
                if (out_free) begin
                    emit      = 1'b1;
                    res.unit  = r_job.req.unit;
                    res.last  = 1'b1;
                    n_state   = S_IDLE;
                    case (r_job.kind)
                        tbrs_pkg::J_OPEN_REF: begin
                            res.kind = tbrs_pkg::RK_REFUSE;
                        end
                        tbrs_pkg::J_REQ_FAIL: begin
                            res.kind   = tbrs_pkg::RK_DONE;
                            res.failed = 1'b1;
                        end
                        tbrs_pkg::J_REQ_ZERO: begin
                            res.kind = tbrs_pkg::RK_DONE;
                            res.zf   = 1'b1;
                        end
                        default: begin
                            res.kind   = tbrs_pkg::RK_REG;
                            res.status = {5'd0, r_job.req.unit, 8'd0} | tbrs_pkg::C_DENS
                                         | tbrs_pkg::C_WEOF | tbrs_pkg::C_GO;
                            res.last   = 1'b0;
                            n_state    = S_REW;
                        end
                    endcase
                end
            end
            S_REW: begin
                if (out_free) begin
                    emit       = 1'b1;
                    res.kind   = tbrs_pkg::RK_REG;
                    res.unit   = r_job.req.unit;
                    res.status = {5'd0, r_job.req.unit, 8'd0} | tbrs_pkg::C_DENS
                                 | tbrs_pkg::C_REW | tbrs_pkg::C_GO;
                    res.last   = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            S_LOAD: begin
                n_state = r_after_intr ? S_INTR : S_START;
            end
            S_START: begin
                if (out_free) begin
                    emit     = 1'b1;
                    res.unit = r_hdata.unit;
                    n_state  = S_IDLE;
                    if (r_ustate[hu] == tbrs_pkg::ST_FAILED || !r_job.ready) begin
                        res.kind     = tbrs_pkg::RK_DONE;
                        res.failed   = 1'b1;
                        do_pop       = 1'b1;
                        res.last     = (r_count == CW'(1));
                        n_after_intr = 1'b0;
                        if (r_count != CW'(1)) begin
                            n_state = S_LOAD;
                        end
                    end else begin
                        res.kind = tbrs_pkg::RK_REG;
                        res.last = 1'b1;
                        if (hpos != r_hdata.block) begin
                            n_phase = tbrs_pkg::PH_SEEK;
                            if (hpos < r_hdata.block) begin
                                res.status = com | tbrs_pkg::C_SFWD | tbrs_pkg::C_GO;
                                res.count  = hpos - r_hdata.block;
                                res.cv     = 1'b1;
                            end else if (r_hdata.block == 16'd0) begin
                                res.status = com | tbrs_pkg::C_REW | tbrs_pkg::C_GO;
                            end else begin
                                res.status = com | tbrs_pkg::C_SREV | tbrs_pkg::C_GO;
                                res.count  = r_hdata.block - hpos;
                                res.cv     = 1'b1;
                            end
                        end else begin
                            n_phase = tbrs_pkg::PH_IO;
                            if (!r_hdata.wr) begin
                                res.status = com | tbrs_pkg::C_READ | tbrs_pkg::C_GO;
                            end else if (r_ec != 4'd0) begin
                                res.status = com | tbrs_pkg::C_WGAP | tbrs_pkg::C_GO;
                            end else begin
                                res.status = com | tbrs_pkg::C_WRITE | tbrs_pkg::C_GO;
                            end
                            res.count = {r_hdata.wc[14:0], 1'b0};
                            res.cv    = 1'b1;
                            res.addr  = r_hdata.addr;
                            res.av    = 1'b1;
                        end
                    end
                end
            end
            S_INTR: begin
                if (out_free) begin
                    if (soft_err && ec1 < i_retry_limit) begin
                        n_ec    = ec1;
                        pos_we  = 1'b1;
                        pos_wd  = hpos + 16'd1;
                        n_phase = tbrs_pkg::PH_IDLE;
                        n_state = S_START;
                    end else begin
                        if (r_job.cerr) begin
                            fail = 1'b1;
                            if (!soft_err && !r_hdata.raw &&
                                (r_job.err & tbrs_pkg::E_EOF) == 16'd0) begin
                                us_we = 1'b1;
                                us_wd = tbrs_pkg::ST_FAILED;
                            end
                        end
                        if (r_job.cerr || r_phase == tbrs_pkg::PH_IO) begin
                            n_ec         = 4'd0;
                            pos_we       = 1'b1;
                            pos_wd       = hpos + 16'd1;
                            do_pop       = 1'b1;
                            n_phase      = tbrs_pkg::PH_IDLE;
                            emit         = 1'b1;
                            res.kind     = tbrs_pkg::RK_DONE;
                            res.unit     = r_hdata.unit;
                            res.failed   = fail;
                            res.resid    = r_job.bc;
                            res.last     = (r_count == CW'(1));
                            n_after_intr = 1'b0;
                            n_state      = (r_count == CW'(1)) ? S_IDLE : S_LOAD;
                        end else begin
                            pos_we  = 1'b1;
                            pos_wd  = r_hdata.block;
                            n_state = S_START;
                        end
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_tptr] <= i_job.req;
        end
        r_hdata <= r_mem[r_hptr];
        if (o_jq_pop) begin
            r_job <= i_job;
        end
        if (emit) begin
            r_res <= res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_after_intr <= 1'b0;
            r_phase      <= tbrs_pkg::PH_IDLE;
            r_ec         <= 4'd0;
            r_hptr       <= '0;
            r_tptr       <= '0;
            r_count      <= '0;
            r_ovalid     <= 1'b0;
            for (int k = 0; k < UNIT_COUNT; k++) begin
                r_ustate[k] <= tbrs_pkg::ST_CLOSED;
                r_pos[k]    <= 16'd0;
            end
        end else begin
            r_state      <= n_state;
            r_after_intr <= n_after_intr;
            r_phase      <= n_phase;
            r_ec         <= n_ec;
            if (do_push) begin
                r_tptr  <= (r_tptr == QIW'(QUEUE_DEPTH - 1)) ? '0 : r_tptr + 1'b1;
                r_count <= r_count + 1'b1;
            end
            if (do_pop) begin
                r_hptr  <= (r_hptr == QIW'(QUEUE_DEPTH - 1)) ? '0 : r_hptr + 1'b1;
                r_count <= r_count - 1'b1;
            end
            if (emit) begin
                r_ovalid <= 1'b1;
            end else if (!i_stall) begin
                r_ovalid <= 1'b0;
            end
            if (us_we) begin
                r_ustate[us_wa] <= us_wd;
            end
            if (pos_we) begin
                r_pos[pos_wa] <= pos_wd;
            end
        end
    end

    always_comb begin
        for (int k = 0; k < UNIT_COUNT; k++) begin
            o_closed[k] = (r_ustate[k] == tbrs_pkg::ST_CLOSED);
        end
    end

    assign o_bstat.idle = (r_state == S_IDLE);
    assign o_bstat.full = (r_count == CW'(QUEUE_DEPTH));
    assign o_valid      = r_ovalid;
    assign o_res        = r_res;

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(QUEUE_DEPTH))
        else $error("request fifo count beyond depth");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && i_stall) |=> (r_ovalid && $stable(r_res)))
        else $error("stalled result changed");

    a_start_has_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_START || r_state == S_INTR) |-> (r_count != '0))
        else $error("head evaluated with empty request fifo");

    a_no_push_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(do_push && do_pop))
        else $error("push and pop in one cycle");

endmodule

// File: tb/sv/tape_block_request_sequencer_chk.sv
// ----------------------------------------------------------------------------
// tape_block_request_sequencer_chk
// watches the event and result channels of the tape block request sequencer,
// predicts the register writes and completions each accepted event causes and
// compares every result field against the oldest prediction
// ----------------------------------------------------------------------------
module tape_block_request_sequencer_chk (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  logic            i_in_stall,
    input  logic [2:0]      i_command,
    input  logic [2:0]      i_unit,
    input  logic [15:0]     i_block,
    input  logic            i_access_write,
    input  logic [1:0]      i_addr_ext,
    input  logic [15:0]     i_word_count,
    input  logic [15:0]     i_core_addr,
    input  logic            i_is_raw,
    input  logic            i_ctrl_ready,
    input  logic            i_ctrl_error,
    input  logic [15:0]     i_error_reg,
    input  logic [15:0]     i_byte_residual,
    input  logic            i_out_valid,
    input  logic            i_out_stall,
    input  tbrs_pkg::t_res  i_res,
    input  logic            i_cfg_we,
    input  logic [3:0]      i_cfg_retry,
    output int              o_fail_count,
    output int              o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int UNITS = 8;
    localparam int DEPTH = 16;

    logic [1:0]       unit_state [UNITS];
    logic [15:0]      position [UNITS];
    logic [15:0]      rec_limit [UNITS];
    tbrs_pkg::t_req   req_queue [$];
    tbrs_pkg::t_phase phase;
    logic [3:0]       soft_errs;
    logic [3:0]       retry_lim;
    tbrs_pkg::t_res   expected_results [$];
    tbrs_pkg::t_res   batch [$];

    function automatic tbrs_pkg::t_res mk(logic [1:0] k, logic [2:0] u, logic [15:0] st,
                                          logic [15:0] cnt, logic cv, logic [15:0] ad,
                                          logic av, logic f, logic zf, logic [15:0] rs);
        tbrs_pkg::t_res r;
        r.kind = k; r.unit = u; r.status = st; r.count = cnt; r.cv = cv;
        r.addr = ad; r.av = av; r.failed = f; r.zf = zf; r.resid = rs;
        r.last = 1'b0;
        return r;
    endfunction

    task automatic serve_head(logic ready);
        tbrs_pkg::t_req r;
        logic [15:0]    com;
        logic [15:0]    pos;
        while (req_queue.size() != 0) begin
            r = req_queue[0];
            pos = position[r.unit];
            if (unit_state[r.unit] == tbrs_pkg::ST_FAILED || !ready) begin
                batch.push_back(mk(tbrs_pkg::RK_DONE, r.unit, 0, 0, 0, 0, 0, 1, 0, 0));
                void'(req_queue.pop_front());
                continue;
            end
            com = ({13'd0, r.unit} << 8) | ({14'd0, r.ext} << 4) | tbrs_pkg::C_IENA
                  | tbrs_pkg::C_DENS;
            if (pos != r.block) begin
                phase = tbrs_pkg::PH_SEEK;
                if (pos < r.block)
                    batch.push_back(mk(tbrs_pkg::RK_REG, r.unit,
                                       com | tbrs_pkg::C_SFWD | tbrs_pkg::C_GO,
                                       pos - r.block, 1, 0, 0, 0, 0, 0));
                else if (r.block == 0)
                    batch.push_back(mk(tbrs_pkg::RK_REG, r.unit,
                                       com | tbrs_pkg::C_REW | tbrs_pkg::C_GO,
                                       0, 0, 0, 0, 0, 0, 0));
                else
                    batch.push_back(mk(tbrs_pkg::RK_REG, r.unit,
                                       com | tbrs_pkg::C_SREV | tbrs_pkg::C_GO,
                                       r.block - pos, 1, 0, 0, 0, 0, 0));
                return;
            end
            phase = tbrs_pkg::PH_IO;
            if (!r.wr) com |= tbrs_pkg::C_READ | tbrs_pkg::C_GO;
            else if (soft_errs != 0) com |= tbrs_pkg::C_WGAP | tbrs_pkg::C_GO;
            else com |= tbrs_pkg::C_WRITE | tbrs_pkg::C_GO;
            batch.push_back(mk(tbrs_pkg::RK_REG, r.unit, com, {r.wc[14:0], 1'b0}, 1,
                               r.addr, 1, 0, 0, 0));
            return;
        end
    endtask

    task automatic take_interrupt(logic ready, logic cerr, logic [15:0] er,
                                  logic [15:0] bc);
        tbrs_pkg::t_req r;
        logic           fl;
        fl = 1'b0;
        if (req_queue.size() == 0) return;
        r = req_queue[0];
        if (cerr) begin
            if ((er & (tbrs_pkg::E_HARD | tbrs_pkg::E_EOF)) == 0 &&
                phase == tbrs_pkg::PH_IO) begin
                soft_errs = 4'(soft_errs + 4'd1);
                if (soft_errs < retry_lim) begin
                    position[r.unit] = 16'(position[r.unit] + 16'd1);
                    phase = tbrs_pkg::PH_IDLE;
                    serve_head(ready);
                    return;
                end
            end else if (!r.raw && (er & tbrs_pkg::E_EOF) == 0) begin
                unit_state[r.unit] = tbrs_pkg::ST_FAILED;
            end
            fl = 1'b1;
            phase = tbrs_pkg::PH_IO;
        end
        if (phase == tbrs_pkg::PH_IO) begin
            soft_errs = 0;
            position[r.unit] = 16'(position[r.unit] + 16'd1);
            void'(req_queue.pop_front());
            phase = tbrs_pkg::PH_IDLE;
            batch.push_back(mk(tbrs_pkg::RK_DONE, r.unit, 0, 0, 0, 0, 0, fl, 0, bc));
        end else begin
            position[r.unit] = r.block;
        end
        serve_head(ready);
    endtask

    task automatic predict_event();
        tbrs_pkg::t_req u_req;
        logic [2:0]     u;
        u = i_unit;
        batch.delete();
        case (i_command)
            tbrs_pkg::CMD_OPEN: begin
                if (unit_state[u] != tbrs_pkg::ST_CLOSED)
                    batch.push_back(mk(tbrs_pkg::RK_REFUSE, u, 0, 0, 0, 0, 0, 0, 0, 0));
                else begin
                    unit_state[u] = tbrs_pkg::ST_OPEN;
                    position[u] = 0;
                    rec_limit[u] = tbrs_pkg::LIMIT_OPEN;
                end
            end
            tbrs_pkg::CMD_CLOSE: begin
                unit_state[u] = tbrs_pkg::ST_CLOSED;
                if (i_access_write)
                    batch.push_back(mk(tbrs_pkg::RK_REG, u, tbrs_pkg::C_DENS
                                       | tbrs_pkg::C_WEOF | tbrs_pkg::C_GO | (16'(u) << 8),
                                       0, 0, 0, 0, 0, 0, 0));
                batch.push_back(mk(tbrs_pkg::RK_REG, u, tbrs_pkg::C_DENS
                                   | tbrs_pkg::C_REW | tbrs_pkg::C_GO | (16'(u) << 8),
                                   0, 0, 0, 0, 0, 0, 0));
            end
            tbrs_pkg::CMD_REQ: begin
                if (req_queue.size() >= DEPTH || rec_limit[u] < i_block)
                    batch.push_back(mk(tbrs_pkg::RK_DONE, u, 0, 0, 0, 0, 0, 1, 0, 0));
                else if (rec_limit[u] == i_block && !i_access_write)
                    batch.push_back(mk(tbrs_pkg::RK_DONE, u, 0, 0, 0, 0, 0, 0, 1, 0));
                else begin
                    if (i_access_write) rec_limit[u] = 16'(i_block + 16'd1);
                    u_req.unit = u; u_req.block = i_block; u_req.wr = i_access_write;
                    u_req.ext = i_addr_ext; u_req.wc = i_word_count;
                    u_req.addr = i_core_addr; u_req.raw = i_is_raw;
                    req_queue.push_back(u_req);
                    if (phase == tbrs_pkg::PH_IDLE) serve_head(i_ctrl_ready);
                end
            end
            tbrs_pkg::CMD_INTR: take_interrupt(i_ctrl_ready, i_ctrl_error, i_error_reg,
                                               i_byte_residual);
            tbrs_pkg::CMD_SETPOS: begin
                position[u] = i_block;
                rec_limit[u] = 16'(i_block + 16'd1);
            end
            default: ;
        endcase
        if (batch.size() > 0) batch[batch.size() - 1].last = 1'b1;
        foreach (batch[k]) expected_results.push_back(batch[k]);
    endtask

    task automatic cmp(string name, logic [15:0] exp_v, logic [15:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s: expected %0h, got %0h", name, exp_v, act_v);
            o_fail_count++;
        end
    endtask

    task automatic check_result();
        tbrs_pkg::t_res e;
        if (expected_results.size() == 0) begin
            $error("unexpected result: kind %0d unit %0d", i_res.kind, i_res.unit);
            o_fail_count++;
            return;
        end
        e = expected_results.pop_front();
        cmp("result_kind", 16'(e.kind), 16'(i_res.kind));
        cmp("unit_res", 16'(e.unit), 16'(i_res.unit));
        cmp("status_word", e.status, i_res.status);
        cmp("count_word", e.count, i_res.count);
        cmp("count_valid", 16'(e.cv), 16'(i_res.cv));
        cmp("address_word", e.addr, i_res.addr);
        cmp("address_valid", 16'(e.av), 16'(i_res.av));
        cmp("failed", 16'(e.failed), 16'(i_res.failed));
        cmp("zero_fill", 16'(e.zf), 16'(i_res.zf));
        cmp("residual", e.resid, i_res.resid);
        cmp("last", 16'(e.last), 16'(i_res.last));
    endtask

    initial begin
        o_fail_count = 0;
        o_pending = 0;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            foreach (unit_state[k]) begin
                unit_state[k] = tbrs_pkg::ST_CLOSED;
                position[k] = 0;
                rec_limit[k] = 0;
            end
            req_queue.delete();
            expected_results.delete();
            phase = tbrs_pkg::PH_IDLE;
            soft_errs = 0;
            retry_lim = tbrs_pkg::RETRY_RESET;
        end else begin
            if (i_out_valid && !i_out_stall) check_result();
            if (i_cfg_we) retry_lim = i_cfg_retry;
            if (i_valid && !i_in_stall) predict_event();
        end
        o_pending = expected_results.size();
    end

endmodule

// File: tb/sv/tape_block_request_sequencer_tb.sv
// ----------------------------------------------------------------------------
// tape_block_request_sequencer_tb
// drives events and retry limit writes into the sequencer with random gaps and
// output stalls; a checker beside the block predicts and compares results
// ----------------------------------------------------------------------------
module tape_block_request_sequencer_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int  N_RANDOM  = 250;
    localparam int  MAX_CYCLE = 400000;
    localparam int  SETTLE    = 40;

    logic           i_clk;
    logic           i_rst_n;
    logic           i_valid;
    logic           o_stall;
    logic [2:0]     i_command;
    logic [2:0]     i_unit;
    logic [15:0]    i_block;
    logic           i_access_write;
    logic [1:0]     i_addr_ext;
    logic [15:0]    i_word_count;
    logic [15:0]    i_core_addr;
    logic           i_is_raw;
    logic           i_ctrl_ready;
    logic           i_ctrl_error;
    logic [15:0]    i_error_reg;
    logic [15:0]    i_byte_residual;
    logic           o_valid;
    logic           i_stall;
    tbrs_pkg::t_res res;
    logic           psel;
    logic           penable;
    logic           pwrite;
    logic [2:0]     paddr;
    logic [31:0]    pwdata;
    logic [31:0]    prdata;
    logic           pready;
    int             fail_count;
    int             pending;
    int             cycle;
    int             out_wait;
    logic           hold_off;

    tape_block_request_sequencer uut (
        .i_clk, .i_rst_n, .i_valid, .o_stall, .i_command, .i_unit, .i_block,
        .i_access_write, .i_addr_ext, .i_word_count, .i_core_addr, .i_is_raw,
        .i_ctrl_ready, .i_ctrl_error, .i_error_reg, .i_byte_residual, .o_valid,
        .i_stall,
        .o_result_kind(res.kind), .o_unit_res(res.unit), .o_status_word(res.status),
        .o_count_word(res.count), .o_count_valid(res.cv), .o_address_word(res.addr),
        .o_address_valid(res.av), .o_failed(res.failed), .o_zero_fill(res.zf),
        .o_residual(res.resid), .o_last(res.last),
        .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
    );

    tape_block_request_sequencer_chk chk (
        .i_clk, .i_rst_n, .i_valid, .i_in_stall(o_stall), .i_command, .i_unit,
        .i_block, .i_access_write, .i_addr_ext, .i_word_count, .i_core_addr,
        .i_is_raw, .i_ctrl_ready, .i_ctrl_error, .i_error_reg, .i_byte_residual,
        .i_out_valid(o_valid), .i_out_stall(i_stall), .i_res(res),
        .i_cfg_we(psel && penable && pwrite && pready && paddr == tbrs_pkg::ADDR_RETRY),
        .i_cfg_retry(pwdata[3:0]),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        cycle = 0;
        forever begin
            @(posedge i_clk);
            cycle++;
            if (cycle > MAX_CYCLE) begin
                $display("** tape_block_request_sequencer: FAILED **");
                $finish;
            end
        end
    end

    // result side: random wait per item, plus one long hold-off on request
    initial begin
        i_stall = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_off) begin
                i_stall <= 1'b1;
                repeat (300) @(posedge i_clk);
                i_stall <= 1'b0;
                wait (!hold_off);
            end else if (o_valid && !i_stall) begin
                out_wait = $urandom_range(0, 10);
                if (out_wait != 0) begin
                    i_stall <= 1'b1;
                    repeat (out_wait) @(posedge i_clk);
                    i_stall <= 1'b0;
                end
            end
        end
    end

    task automatic send(logic [2:0] c, logic [2:0] u, logic [15:0] b, logic w,
                        logic rdy, logic cerr, logic [15:0] er);
        repeat ($urandom_range(0, 10)) @(posedge i_clk);
        i_valid <= 1'b1;
        i_command <= c;
        i_unit <= u;
        i_block <= b;
        i_access_write <= w;
        i_addr_ext <= 2'($urandom);
        i_word_count <= 16'($urandom);
        i_core_addr <= 16'($urandom);
        i_is_raw <= 1'($urandom);
        i_ctrl_ready <= rdy;
        i_ctrl_error <= cerr;
        i_error_reg <= er;
        i_byte_residual <= 16'($urandom);
        do @(posedge i_clk); while (o_stall);
        i_valid <= 1'b0;
    endtask

    task automatic drain();
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic set_retry(logic [3:0] v);
        psel <= 1'b1; pwrite <= 1'b1; paddr <= tbrs_pkg::ADDR_RETRY; pwdata <= 32'(v);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic [15:0] pick_err();
        case ($urandom_range(0, 3))
            0: return 16'($urandom);
            1: return tbrs_pkg::E_EOF;
            2: return tbrs_pkg::E_HARD;
            default: return 16'($urandom) & ~(tbrs_pkg::E_HARD | tbrs_pkg::E_EOF);
        endcase
    endfunction

    task automatic random_event(logic [2:0] u);
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 40)
            send(tbrs_pkg::CMD_REQ, u, 16'($urandom_range(0, 12)), 1'($urandom),
                 $urandom_range(0, 9) != 0, 0, 0);
        else if (sel < 75)
            send(tbrs_pkg::CMD_INTR, u, 0, 0, $urandom_range(0, 9) != 0,
                 $urandom_range(0, 2) == 0, pick_err());
        else if (sel < 82)
            send(tbrs_pkg::CMD_OPEN, u, 0, 0, 1, 0, 0);
        else if (sel < 87)
            send(tbrs_pkg::CMD_CLOSE, u, 0, 1'($urandom), 1, 0, 0);
        else if (sel < 93)
            send(tbrs_pkg::CMD_SETPOS, u, $urandom_range(0, 3) == 0 ? 16'($urandom) :
                 16'($urandom_range(0, 10)), 0, 1, 0, 0);
        else if (sel < 97)
            send(tbrs_pkg::CMD_REQ, u, 16'($urandom), 1'($urandom), 1'($urandom), 0, 0);
        else
            send(3'($urandom_range(5, 7)), u, 16'($urandom), 1'($urandom), 1,
                 1'($urandom), 16'($urandom));
    endtask

    initial begin
        i_rst_n = 1'b0; i_valid = 1'b0; i_command = tbrs_pkg::CMD_OPEN; i_unit = 0;
        i_block = 0; i_access_write = 0; i_addr_ext = 0; i_word_count = 0;
        i_core_addr = 0; i_is_raw = 0; i_ctrl_ready = 0; i_ctrl_error = 0;
        i_error_reg = 0; i_byte_residual = 0; hold_off = 1'b0;
        psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: open, refusal, limits, seeks, wrap, interrupts, close
        send(tbrs_pkg::CMD_REQ, 3, 5, 0, 1, 0, 0);
        send(tbrs_pkg::CMD_OPEN, 0, 0, 0, 1, 0, 0);
        send(tbrs_pkg::CMD_OPEN, 0, 0, 0, 1, 0, 0);
        send(tbrs_pkg::CMD_OPEN, 7, 0, 0, 1, 0, 0);
        send(tbrs_pkg::CMD_REQ, 0, 0, 1, 1, 0, 0);
        send(tbrs_pkg::CMD_REQ, 0, 3, 0, 1, 0, 0);
        send(tbrs_pkg::CMD_REQ, 0, 1, 0, 1, 0, 0);
        send(tbrs_pkg::CMD_INTR, 0, 0, 0, 1, 1, 16'h0001);
        send(tbrs_pkg::CMD_INTR, 0, 0, 0, 1, 0, 0);
        send(tbrs_pkg::CMD_INTR, 0, 0, 0, 1, 0, 0);
        send(tbrs_pkg::CMD_INTR, 0, 0, 0, 1, 0, 0);
        send(tbrs_pkg::CMD_INTR, 0, 0, 0, 1, 0, 0);
        send(tbrs_pkg::CMD_REQ, 7, 16'hFFFF, 1, 1, 0, 0);
        send(tbrs_pkg::CMD_SETPOS, 7, 16'hFFFF, 0, 1, 0, 0);
        send(tbrs_pkg::CMD_REQ, 7, 0, 0, 1, 0, 0);
        send(tbrs_pkg::CMD_SETPOS, 6, 16'hFFFE, 0, 1, 0, 0);
        send(tbrs_pkg::CMD_REQ, 6, 16'hFFFF, 0, 1, 0, 0);
        send(tbrs_pkg::CMD_REQ, 7, 0, 1, 0, 0, 0);
        send(tbrs_pkg::CMD_INTR, 0, 0, 0, 1, 1, tbrs_pkg::E_HARD);
        send(tbrs_pkg::CMD_INTR, 0, 0, 0, 1, 1, tbrs_pkg::E_EOF);
        send(tbrs_pkg::CMD_CLOSE, 0, 0, 1, 1, 0, 0);
        send(tbrs_pkg::CMD_CLOSE, 7, 0, 0, 1, 0, 0);
        send(3'd6, 2, 16'hFFFF, 1, 1, 1, 16'hFFFF);
        drain();

        // random phases over several retry limits
        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0: set_retry(4'd1);
                1: set_retry(4'd15);
                2: set_retry(4'd3);
                3: set_retry(4'd0);
                default: set_retry(4'($urandom_range(1, 15)));
            endcase
            for (int k = 0; k < 8; k++) send(tbrs_pkg::CMD_OPEN, 3'(k), 0, 0, 1, 0, 0);
            if (ph == 1) hold_off = 1'b1;
            for (int k = 0; k < N_RANDOM / 5; k++)
                random_event(3'($urandom_range(0, 3) == 0 ? $urandom_range(0, 7) :
                                $urandom_range(0, 1)));
            hold_off = 1'b0;
            drain();
        end

        if (fail_count == 0 && pending == 0)
            $display("** tape_block_request_sequencer: PASSED **");
        else
            $display("** tape_block_request_sequencer: FAILED **");
        $finish;
    end

endmodule

// File: files.f
rtl/core/tbrs_pkg.sv
rtl/core/tbrs_jobq.sv
rtl/core/tbrs_front.sv
rtl/core/tbrs_back.sv
rtl/core/tape_block_request_sequencer.sv
tb/sv/tape_block_request_sequencer_chk.sv
tb/sv/tape_block_request_sequencer_tb.sv
